[src/sdspi_pkg.sv]
// Shared types, codes and CRC helpers for the SD SPI-mode command transaction.
// No dependencies; imported by every module of the block.
`default_nettype none

package sdspi_pkg;

  localparam int MAX_BLOCK = 512;
  localparam int LEN_W     = $clog2(MAX_BLOCK + 1);
  localparam int CMD_BYTES = 5;
  localparam int EXT_BYTES = 4;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_BYTE  = 1'b1;

  localparam logic [1:0] RT_R1 = 2'd0;
  localparam logic [1:0] RT_R2 = 2'd1;
  localparam logic [1:0] RT_R7 = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_RESP_TOUT = 3'd1;
  localparam logic [2:0] ST_CARD_ERR  = 3'd2;
  localparam logic [2:0] ST_TOK_TOUT  = 3'd3;
  localparam logic [2:0] ST_CRC_ERR   = 3'd4;

  localparam logic [7:0] BYTE_POLL  = 8'hFF;
  localparam logic [7:0] BYTE_TOKEN = 8'hFE;
  localparam logic [7:0] R1_IDLE    = 8'h01;
  localparam logic [7:0] R1_ERRMASK = 8'hFE;
  localparam logic [1:0] CMD_START  = 2'b01;
  localparam logic [7:0] CRC7_POLY  = 8'h89;
  localparam logic [15:0] CRC16_POLY = 16'h1021;

  localparam logic [15:0] RESP_TRIES_RST = 16'd1000;
  localparam logic [15:0] TOK_TRIES_RST  = 16'd20000;
  localparam logic [3:0]  TRAIL_RST      = 4'd8;

  localparam logic [1:0] REG_RESP_TRIES = 2'd0;
  localparam logic [1:0] REG_TOK_TRIES  = 2'd1;
  localparam logic [1:0] REG_TRAIL      = 2'd2;

  typedef enum logic [9:0] {
    PH_IDLE  = 10'b00_0000_0001,
    PH_CMD   = 10'b00_0000_0010,
    PH_RESP  = 10'b00_0000_0100,
    PH_R2B   = 10'b00_0000_1000,
    PH_EXT   = 10'b00_0001_0000,
    PH_TOKEN = 10'b00_0010_0000,
    PH_DATA  = 10'b00_0100_0000,
    PH_CRCHI = 10'b00_1000_0000,
    PH_CRCLO = 10'b01_0000_0000,
    PH_TRAIL = 10'b10_0000_0000
  } phase_t;

  typedef struct packed {
    logic        kind;
    logic [5:0]  cmd_index;
    logic [31:0] cmd_arg;
    logic [1:0]  resp_type;
    logic        read_block;
    logic [9:0]  data_len;
    logic [7:0]  rx_byte;
  } req_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        cs_active;
    logic        data_valid;
    logic [7:0]  data_byte;
    logic        done_res;
    logic [2:0]  status;
    logic [7:0]  r1_value;
    logic [31:0] resp_ext;
  } res_t;

  typedef struct packed {
    logic [15:0] response_tries;
    logic [15:0] token_tries;
    logic [3:0]  trailing_dummies;
  } cfg_t;

  // CRC7 over one byte, MSB first; result kept left-aligned (bit 0 zero)
  function automatic logic [7:0] crc7_upd(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] t;
    t = acc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (t[7]) t = t ^ CRC7_POLY;
      t = {t[6:0], 1'b0};
    end
    return t;
  endfunction

  // CRC16-CCITT, init 0, one byte MSB first
  function automatic logic [15:0] crc16_upd(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    c = acc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC16_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[src/sdspi_regs.sv]
// APB-style configuration registers: response tries, token tries, trailing dummies.
// Depends on sdspi_pkg.
`default_nettype none

module sdspi_regs
  import sdspi_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output cfg_t             cfg
);

  cfg_t cfg_r;
  logic wr_en;

  assign wr_en = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.response_tries   <= RESP_TRIES_RST;
      cfg_r.token_tries      <= TOK_TRIES_RST;
      cfg_r.trailing_dummies <= TRAIL_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_RESP_TRIES: cfg_r.response_tries   <= pwdata[15:0];
        REG_TOK_TRIES:  cfg_r.token_tries      <= pwdata[15:0];
        REG_TRAIL:      cfg_r.trailing_dummies <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_RESP_TRIES: prdata = {16'h0000, cfg_r.response_tries};
      REG_TOK_TRIES:  prdata = {16'h0000, cfg_r.token_tries};
      REG_TRAIL:      prdata = {28'h0000000, cfg_r.trailing_dummies};
      default:        prdata = 32'h0000_0000;
    endcase
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

[src/sdspi_in_stage.sv]
// Input register stage: holds one accepted item until the engine consumes it.
// Depends on sdspi_pkg.
`default_nettype none

module sdspi_in_stage
  import sdspi_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire req_t in_req,
  input  wire logic take,
  output logic      req_valid,
  output req_t      req
);

  logic valid_r;
  req_t req_r;

  assign in_ready  = !valid_r || take;
  assign req_valid = valid_r;
  assign req       = req_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req_r <= in_req;
    end
  end

endmodule

`default_nettype wire

[src/sdspi_engine.sv]
// Transaction engine: phase state plus one byte-exchange step of next-state logic.
// Depends on sdspi_pkg (types, codes, CRC helpers).
`default_nettype none

module sdspi_engine
  import sdspi_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic step,
  input  wire req_t req,
  input  wire cfg_t cfg,
  output res_t      res
);

  phase_t            phase_r, phase_nxt;
  logic [LEN_W-1:0]  bc_r, bc_nxt, bc_inc;
  logic [15:0]       tries_r, tries_nxt;
  logic [7:0]        crc7_r, crc7_nxt;
  logic [15:0]       crc16_r, crc16_nxt;
  logic [31:0]       arg_r, arg_nxt;
  logic [7:0]        resp_r, resp_nxt;
  logic [31:0]       ext_r, ext_nxt;
  logic [7:0]        crchi_r, crchi_nxt;
  logic [1:0]        rtype_r, rtype_nxt;
  logic              rdblk_r, rdblk_nxt;
  logic [9:0]        len_r, len_nxt;
  logic [2:0]        status_r, status_nxt;
  logic [LEN_W-1:0]  eff_len;
  logic [7:0]        frame_byte;
  logic [7:0]        rx;
  logic go_poll, go_finish, go_trail, go_resp_done;

  assign rx     = req.rx_byte;
  assign bc_inc = bc_r + LEN_W'(1);
  assign eff_len = (32'(len_r) > MAX_BLOCK) ? LEN_W'(MAX_BLOCK) : LEN_W'(len_r);

  always_comb begin
    case (bc_inc[2:0])
      3'd1:    frame_byte = arg_r[31:24];
      3'd2:    frame_byte = arg_r[23:16];
      3'd3:    frame_byte = arg_r[15:8];
      default: frame_byte = arg_r[7:0];
    endcase
  end

  always_comb begin
    phase_nxt  = phase_r;
    bc_nxt     = bc_r;
    tries_nxt  = tries_r;
    crc7_nxt   = crc7_r;
    crc16_nxt  = crc16_r;
    arg_nxt    = arg_r;
    resp_nxt   = resp_r;
    ext_nxt    = ext_r;
    crchi_nxt  = crchi_r;
    rtype_nxt  = rtype_r;
    rdblk_nxt  = rdblk_r;
    len_nxt    = len_r;
    status_nxt = status_r;
    res        = '0;
    go_poll      = 1'b0;
    go_finish    = 1'b0;
    go_trail     = 1'b0;
    go_resp_done = 1'b0;

    if (req.kind == KIND_START) begin
      arg_nxt    = req.cmd_arg;
      crc7_nxt   = crc7_upd(8'h00, {CMD_START, req.cmd_index});
      rtype_nxt  = req.resp_type;
      rdblk_nxt  = req.read_block;
      len_nxt    = req.data_len;
      resp_nxt   = BYTE_POLL;
      ext_nxt    = '0;
      crchi_nxt  = '0;
      crc16_nxt  = '0;
      status_nxt = ST_OK;
      bc_nxt     = '0;
      tries_nxt  = '0;
      phase_nxt  = PH_CMD;
      res.tx_valid  = 1'b1;
      res.tx_byte   = {CMD_START, req.cmd_index};
      res.cs_active = 1'b1;
    end else begin
      case (phase_r)
        PH_CMD: begin
          bc_nxt = bc_inc;
          if (bc_inc < LEN_W'(CMD_BYTES)) begin
            crc7_nxt      = crc7_upd(crc7_r, frame_byte);
            res.tx_valid  = 1'b1;
            res.tx_byte   = frame_byte;
            res.cs_active = 1'b1;
          end else if (bc_inc == LEN_W'(CMD_BYTES)) begin
            res.tx_valid  = 1'b1;
            res.tx_byte   = crc7_r | 8'h01;
            res.cs_active = 1'b1;
          end else begin
            tries_nxt = (cfg.response_tries == '0) ? '0 : cfg.response_tries - 16'd1;
            phase_nxt = PH_RESP;
            go_poll   = 1'b1;
          end
        end
        PH_RESP: begin
          if (!rx[7]) begin
            resp_nxt = rx;
            if (rtype_r == RT_R2) begin
              phase_nxt = PH_R2B;
              go_poll   = 1'b1;
            end else if (rtype_r == RT_R7 && rx == R1_IDLE) begin
              bc_nxt    = '0;
              phase_nxt = PH_EXT;
              go_poll   = 1'b1;
            end else begin
              go_resp_done = 1'b1;
            end
          end else if (tries_r == '0) begin
            resp_nxt   = BYTE_POLL;
            status_nxt = ST_RESP_TOUT;
            if (rdblk_r) go_finish = 1'b1;
            else         go_trail  = 1'b1;
          end else begin
            tries_nxt = tries_r - 16'd1;
            go_poll   = 1'b1;
          end
        end
        PH_R2B: begin
          ext_nxt      = {24'h000000, rx};
          go_resp_done = 1'b1;
        end
        PH_EXT: begin
          ext_nxt = {ext_r[23:0], rx};
          bc_nxt  = bc_inc;
          if (bc_inc >= LEN_W'(EXT_BYTES)) go_resp_done = 1'b1;
          else                            go_poll      = 1'b1;
        end
        PH_TOKEN: begin
          if (rx == BYTE_TOKEN) begin
            bc_nxt    = '0;
            crc16_nxt = '0;
            phase_nxt = (eff_len == '0) ? PH_CRCHI : PH_DATA;
            go_poll   = 1'b1;
          end else if (tries_r == '0) begin
            status_nxt = ST_TOK_TOUT;
            go_trail   = 1'b1;
          end else begin
            tries_nxt = tries_r - 16'd1;
            go_poll   = 1'b1;
          end
        end
        PH_DATA: begin
          crc16_nxt = crc16_upd(crc16_r, rx);
          bc_nxt    = bc_inc;
          if (bc_inc >= eff_len) phase_nxt = PH_CRCHI;
          res.data_valid = 1'b1;
          res.data_byte  = rx;
          go_poll        = 1'b1;
        end
        PH_CRCHI: begin
          crchi_nxt = rx;
          phase_nxt = PH_CRCLO;
          go_poll   = 1'b1;
        end
        PH_CRCLO: begin
          if ({crchi_r, rx} != crc16_r) status_nxt = ST_CRC_ERR;
          go_trail = 1'b1;
        end
        PH_TRAIL: begin
          if (bc_r == '0) begin
            go_finish = 1'b1;
          end else begin
            bc_nxt  = bc_r - LEN_W'(1);
            go_poll = 1'b1;
          end
        end
        default: begin
          // byte with no transaction open: empty result
          phase_nxt = PH_IDLE;
        end
      endcase
    end

    // response complete: either trail out, abort on card error, or hunt the token
    if (go_resp_done) begin
      if (!rdblk_r) begin
        go_trail = 1'b1;
      end else if ((resp_nxt & R1_ERRMASK) != 8'h00) begin
        status_nxt = ST_CARD_ERR;
        go_finish  = 1'b1;
      end else begin
        tries_nxt = (cfg.token_tries == '0) ? '0 : cfg.token_tries - 16'd1;
        phase_nxt = PH_TOKEN;
        go_poll   = 1'b1;
      end
    end

    if (go_trail) begin
      if (cfg.trailing_dummies == '0) begin
        go_finish = 1'b1;
      end else begin
        bc_nxt    = LEN_W'(cfg.trailing_dummies) - LEN_W'(1);
        phase_nxt = PH_TRAIL;
        go_poll   = 1'b1;
      end
    end

    if (go_poll) begin
      res.tx_valid  = 1'b1;
      res.tx_byte   = BYTE_POLL;
      res.cs_active = 1'b1;
    end

    if (go_finish) begin
      phase_nxt    = PH_IDLE;
      res.done_res = 1'b1;
      res.status   = status_nxt;
      res.r1_value = resp_nxt;
      res.resp_ext = ext_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      bc_r     <= '0;
      tries_r  <= '0;
      crc7_r   <= '0;
      crc16_r  <= '0;
      arg_r    <= '0;
      resp_r   <= BYTE_POLL;
      ext_r    <= '0;
      crchi_r  <= '0;
      rtype_r  <= '0;
      rdblk_r  <= 1'b0;
      len_r    <= '0;
      status_r <= ST_OK;
    end else if (step) begin
      phase_r  <= phase_nxt;
      bc_r     <= bc_nxt;
      tries_r  <= tries_nxt;
      crc7_r   <= crc7_nxt;
      crc16_r  <= crc16_nxt;
      arg_r    <= arg_nxt;
      resp_r   <= resp_nxt;
      ext_r    <= ext_nxt;
      crchi_r  <= crchi_nxt;
      rtype_r  <= rtype_nxt;
      rdblk_r  <= rdblk_nxt;
      len_r    <= len_nxt;
      status_r <= status_nxt;
    end
  end

endmodule

`default_nettype wire

[src/sdspi_out_stage.sv]
// Result register: holds one result item until the downstream side takes it.
// Depends on sdspi_pkg.
`default_nettype none

module sdspi_out_stage
  import sdspi_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic load,
  input  wire res_t res_in,
  output logic      can_load,
  output logic      out_valid,
  input  wire logic out_ready,
  output res_t      res_out
);

  logic valid_r;
  res_t res_r;

  assign can_load  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign res_out   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_load) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

endmodule

`default_nettype wire

[src/sd_spi_command_transaction.sv]
// Top level of the SD SPI-mode command transaction (host side, one byte per item).
// Depends on sdspi_pkg, sdspi_regs, sdspi_in_stage, sdspi_engine, sdspi_out_stage.
//
//  Channel  | Handshake              | Payload
//  ---------+------------------------+-----------------------------------------
//  in_      | in_tvalid / in_tready  | tdata: request fields, tuser: kind
//  out_     | out_tvalid / out_tready| tdata: result fields, tlast: done
//  cfg_     | APB psel/penable       | 3 registers at byte addresses 0, 4, 8
//
// One item per cycle sustained while the output is not stalled. Each item sits in
// the input register until a single step of the transaction engine writes the
// result register, which raises out_tvalid; the result is taken when out_tready
// is high. A stalled output holds its result while the input register still
// takes one more item. Reset (rst_n low, synchronous) clears the phase to idle
// and loads the register defaults
// (1000 response tries, 20000 token tries, 8 trailing dummies).
`default_nettype none

module sd_spi_command_transaction
  import sdspi_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input items
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [5:0] cmd_index, [37:6] cmd_arg, [39:38] resp_type, [40] read_block,
  // [50:41] data_len, [58:51] rx_byte, [63:59] zero
  input  wire logic [63:0] in_tdata,
  // [0] kind: 0 start command, 1 received byte
  input  wire logic        in_tuser,
  // result items
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [0] tx_valid, [8:1] tx_byte, [9] cs_active, [10] data_valid, [18:11] data_byte,
  // [21:19] status, [29:22] r1_value, [61:30] resp_ext, [63:62] zero
  output logic [63:0]      out_tdata,
  output logic             out_tlast,   // done_res
  // configuration
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  cfg_t cfg;
  req_t in_req, req;
  res_t eng_res, res_q;
  logic req_valid, can_load, step;

  assign cfg_pready = 1'b1;

  // unpack the input item
  assign in_req.kind       = in_tuser;
  assign in_req.cmd_index  = in_tdata[5:0];
  assign in_req.cmd_arg    = in_tdata[37:6];
  assign in_req.resp_type  = in_tdata[39:38];
  assign in_req.read_block = in_tdata[40];
  assign in_req.data_len   = in_tdata[50:41];
  assign in_req.rx_byte    = in_tdata[58:51];

  // engine advances whenever an item is waiting and the result slot is free
  assign step = req_valid && can_load;

  sdspi_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  sdspi_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_req    (in_req),
    .take      (step),
    .req_valid (req_valid),
    .req       (req)
  );

  sdspi_engine u_eng (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .req   (req),
    .cfg   (cfg),
    .res   (eng_res)
  );

  sdspi_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step),
    .res_in    (eng_res),
    .can_load  (can_load),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .res_out   (res_q)
  );

  // pack the result item
  assign out_tdata = {2'b00, res_q.resp_ext, res_q.r1_value, res_q.status,
                      res_q.data_byte, res_q.data_valid, res_q.cs_active,
                      res_q.tx_byte, res_q.tx_valid};
  assign out_tlast = res_q.done_res;

endmodule

`default_nettype wire

[verif/testbench.sv]
// Self-checking testbench for sd_spi_command_transaction: plays the SD card on the byte
// stream, predicts every result and checks it field by field in a small scoreboard class.
// Depends on sdspi_pkg (types and codes) and the RTL top level.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sdspi_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;

  // ---------------------------------------------------------------------------
  // Transaction predictor and result store. One expected result per accepted item.
  // ---------------------------------------------------------------------------
  class sd_txn_scoreboard;
    logic [15:0] resp_tries_cfg;
    logic [15:0] tok_tries_cfg;
    logic [3:0]  trail_cfg;

    phase_t      phase;
    logic [9:0]  count;
    logic [15:0] tries;
    logic [7:0]  crc7;
    logic [15:0] crc16;
    logic [15:0] rx_crc;
    logic [39:0] frame;
    logic [7:0]  r1;
    logic [31:0] ext;
    logic [1:0]  rtype;
    logic        rd_block;
    logic [9:0]  blk_len;
    logic [2:0]  status;

    res_t expected_q[$];
    int   errors;
    int   checked;
    int   done_cnt;
    int   block_bytes;
    int   status_cnt[5];

    function new();
      resp_tries_cfg = RESP_TRIES_RST;
      tok_tries_cfg  = TOK_TRIES_RST;
      trail_cfg      = TRAIL_RST;
      phase    = PH_IDLE;
      count    = '0;
      tries    = '0;
      crc7     = '0;
      crc16    = '0;
      rx_crc   = '0;
      frame    = '0;
      r1       = BYTE_POLL;
      ext      = '0;
      rtype    = RT_R1;
      rd_block = 1'b0;
      blk_len  = '0;
      status   = ST_OK;
      errors   = 0;
      checked  = 0;
      done_cnt = 0;
      block_bytes = 0;
      foreach (status_cnt[i]) status_cnt[i] = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_RESP_TRIES: resp_tries_cfg = value[15:0];
        REG_TOK_TRIES:  tok_tries_cfg  = value[15:0];
        REG_TRAIL:      trail_cfg      = value[3:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // MSB-first CRC7, kept left-aligned so the frame byte is crc | stop bit
    function logic [7:0] crc7_next(logic [7:0] acc, logic [7:0] b);
      logic [7:0] t;
      logic       fb;
      t = acc;
      for (int i = 7; i >= 0; i--) begin
        fb = t[7] ^ b[i];
        t  = {t[6:0], 1'b0};
        if (fb) t = t ^ {CRC7_POLY[6:0], 1'b0};
      end
      return t;
    endfunction

    function logic [15:0] crc16_next(logic [15:0] acc, logic [7:0] b);
      logic [15:0] c;
      logic        fb;
      c = acc;
      for (int i = 7; i >= 0; i--) begin
        fb = c[15] ^ b[i];
        c  = {c[14:0], 1'b0};
        if (fb) c = c ^ CRC16_POLY;
      end
      return c;
    endfunction

    function logic [9:0] block_len();
      return (blk_len > 10'(MAX_BLOCK)) ? 10'(MAX_BLOCK) : blk_len;
    endfunction

    function res_t poll_res(logic dv, logic [7:0] db);
      res_t r;
      r = '0;
      r.tx_valid   = 1'b1;
      r.tx_byte    = BYTE_POLL;
      r.cs_active  = 1'b1;
      r.data_valid = dv;
      r.data_byte  = dv ? db : 8'h00;
      return r;
    endfunction

    function res_t close_txn(logic dv, logic [7:0] db);
      res_t r;
      r = '0;
      r.data_valid = dv;
      r.data_byte  = dv ? db : 8'h00;
      r.done_res   = 1'b1;
      r.status     = status;
      r.r1_value   = r1;
      r.resp_ext   = ext;
      phase = PH_IDLE;
      done_cnt++;
      status_cnt[status]++;
      return r;
    endfunction

    function res_t start_trailer(logic dv, logic [7:0] db);
      if (trail_cfg == 4'd0) return close_txn(dv, db);
      count = {6'd0, trail_cfg} - 10'd1;
      phase = PH_TRAIL;
      return poll_res(dv, db);
    endfunction

    // response (and any extension) complete: trailer, card error abort, or token wait
    function res_t response_over();
      if (!rd_block) return start_trailer(1'b0, 8'h00);
      if ((r1 & R1_ERRMASK) != 8'h00) begin
        status = ST_CARD_ERR;
        return close_txn(1'b0, 8'h00);
      end
      tries = (tok_tries_cfg != 16'd0) ? tok_tries_cfg - 16'd1 : 16'd0;
      phase = PH_TOKEN;
      return poll_res(1'b0, 8'h00);
    endfunction

    function void note_item(req_t it);
      res_t       r;
      logic [7:0] rx;
      r  = '0;
      rx = it.rx_byte;
      if (it.kind == KIND_START) begin
        // a start always wins, whatever was in progress
        frame = {CMD_START, it.cmd_index, it.cmd_arg};
        crc7  = '0;
        for (int k = 4; k >= 0; k--) crc7 = crc7_next(crc7, frame[8*k +: 8]);
        rtype    = it.resp_type;
        rd_block = it.read_block;
        blk_len  = it.data_len;
        r1       = BYTE_POLL;
        ext      = '0;
        rx_crc   = '0;
        crc16    = '0;
        status   = ST_OK;
        count    = '0;
        tries    = '0;
        phase    = PH_CMD;
        r.tx_valid  = 1'b1;
        r.tx_byte   = frame[39:32];
        r.cs_active = 1'b1;
      end else begin
        case (phase)
          PH_CMD: begin
            count++;
            if (count < 10'(CMD_BYTES)) begin
              r.tx_valid  = 1'b1;
              r.tx_byte   = frame[8*(4 - int'(count)) +: 8];
              r.cs_active = 1'b1;
            end else if (count == 10'(CMD_BYTES)) begin
              r.tx_valid  = 1'b1;
              r.tx_byte   = crc7 | 8'h01;
              r.cs_active = 1'b1;
            end else begin
              tries = (resp_tries_cfg != 16'd0) ? resp_tries_cfg - 16'd1 : 16'd0;
              phase = PH_RESP;
              r = poll_res(1'b0, 8'h00);
            end
          end
          PH_RESP: begin
            if (!rx[7]) begin
              r1 = rx;
              if (rtype == RT_R2) begin
                phase = PH_R2B;
                r = poll_res(1'b0, 8'h00);
              end else if (rtype == RT_R7 && rx == R1_IDLE) begin
                count = '0;
                phase = PH_EXT;
                r = poll_res(1'b0, 8'h00);
              end else begin
                r = response_over();
              end
            end else if (tries == 16'd0) begin
              r1     = BYTE_POLL;
              status = ST_RESP_TOUT;
              // a block read gives up at once, without the trailer
              if (rd_block) r = close_txn(1'b0, 8'h00);
              else r = start_trailer(1'b0, 8'h00);
            end else begin
              tries--;
              r = poll_res(1'b0, 8'h00);
            end
          end
          PH_R2B: begin
            ext = {24'h0, rx};
            r = response_over();
          end
          PH_EXT: begin
            ext = {ext[23:0], rx};
            count++;
            if (count >= 10'(EXT_BYTES)) r = response_over();
            else r = poll_res(1'b0, 8'h00);
          end
          PH_TOKEN: begin
            if (rx == BYTE_TOKEN) begin
              count = '0;
              crc16 = '0;
              phase = (block_len() == 10'd0) ? PH_CRCHI : PH_DATA;
              r = poll_res(1'b0, 8'h00);
            end else if (tries == 16'd0) begin
              status = ST_TOK_TOUT;
              r = start_trailer(1'b0, 8'h00);
            end else begin
              tries--;
              r = poll_res(1'b0, 8'h00);
            end
          end
          PH_DATA: begin
            crc16 = crc16_next(crc16, rx);
            count++;
            block_bytes++;
            if (count >= block_len()) phase = PH_CRCHI;
            r = poll_res(1'b1, rx);
          end
          PH_CRCHI: begin
            rx_crc = {rx, 8'h00};
            phase  = PH_CRCLO;
            r = poll_res(1'b0, 8'h00);
          end
          PH_CRCLO: begin
            rx_crc[7:0] = rx;
            if (rx_crc != crc16) status = ST_CRC_ERR;
            r = start_trailer(1'b0, 8'h00);
          end
          PH_TRAIL: begin
            if (count == 10'd0) begin
              r = close_txn(1'b0, 8'h00);
            end else begin
              count--;
              r = poll_res(1'b0, 8'h00);
            end
          end
          default: begin
            // byte while idle: ignored, all-zero result
            phase = PH_IDLE;
          end
        endcase
      end
      expected_q.push_back(r);
    endfunction

    function void match(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: %h", got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      match("tx_valid",   want.tx_valid,   got.tx_valid);
      match("tx_byte",    want.tx_byte,    got.tx_byte);
      match("cs_active",  want.cs_active,  got.cs_active);
      match("data_valid", want.data_valid, got.data_valid);
      match("data_byte",  want.data_byte,  got.data_byte);
      match("done_res",   want.done_res,   got.done_res);
      match("status",     want.status,     got.status);
      match("r1_value",   want.r1_value,   got.r1_value);
      match("resp_ext",   want.resp_ext,   got.resp_ext);
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Clock, DUT and its ports
  // ---------------------------------------------------------------------------
  logic clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;    // cmd_index, cmd_arg, resp_type, read_block, data_len, rx_byte
  logic        in_tuser;    // kind
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;   // tx_valid, tx_byte, cs_active, data_valid, data_byte,
                            // status, r1_value, resp_ext
  logic        out_tlast;   // done_res
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  sd_spi_command_transaction dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  sd_txn_scoreboard sb;

  bit quiet         = 1'b0;   // no idling on either side while set
  bit final_stretch = 1'b0;   // last part of the run: idling off for good
  bit resp_mute     = 1'b0;   // card never answers the command
  bit token_mute    = 1'b0;   // card never sends the data token
  int stall_left    = 0;
  int useful_items  = 0;
  int idle_items    = 0;

  // Receiver: random stall bursts on out_tready
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 8);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Result monitor. Sampled at the falling edge: everything is stable until the
  // rising edge that completes the handshake.
  always @(negedge clk) begin
    res_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.tx_valid   = out_tdata[0];
      got.tx_byte    = out_tdata[8:1];
      got.cs_active  = out_tdata[9];
      got.data_valid = out_tdata[10];
      got.data_byte  = out_tdata[18:11];
      got.status     = out_tdata[21:19];
      got.r1_value   = out_tdata[29:22];
      got.resp_ext   = out_tdata[61:30];
      got.done_res   = out_tlast;
      sb.check_result(got);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus tasks. All are entered right after a rising edge.
  // ---------------------------------------------------------------------------

  // Send one item with an optional idle burst in front; note it once accepted.
  task automatic push_item(input req_t it, input bit counted);
    int gap;
    bit ok;
    gap = 0;
    if (!quiet && $urandom_range(0, 6) == 0) gap = $urandom_range(1, 9);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.kind;
    in_tdata  <= {5'd0, it.rx_byte, it.data_len, it.read_block, it.resp_type,
                  it.cmd_arg, it.cmd_index};
    do begin
      @(negedge clk);
      ok = in_tready;
      @(posedge clk);
    end while (!ok);
    sb.note_item(it);
    if (counted) useful_items++;
    else idle_items++;
  endtask

  // Hold off until every expected result is back, then let the pipe settle.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write: setup cycle then access cycle; back-to-back writes allowed.
  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    sb.write_reg(idx, value);
  endtask

  task automatic reconfigure(input logic [15:0] rtries, input logic [15:0] ttries,
                             input logic [3:0] dummies);
    wait_drained();
    cfg_write(REG_RESP_TRIES, {16'd0, rtries});
    cfg_write(REG_TOK_TRIES, {16'd0, ttries});
    cfg_write(REG_TRAIL, {28'd0, dummies});
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  function automatic req_t random_start();
    req_t it;
    it.kind       = KIND_START;
    it.cmd_index  = 6'($urandom);
    it.cmd_arg    = $urandom;
    it.resp_type  = 2'($urandom_range(0, 3));
    it.read_block = 1'($urandom_range(0, 1));
    it.rx_byte    = 8'($urandom);
    // mostly short blocks; now and then a full or oversized one
    case ($urandom_range(0, 79))
      0:          it.data_len = 10'd512;
      1:          it.data_len = 10'($urandom_range(513, 1023));
      2:          it.data_len = 10'($urandom);
      3, 4, 5, 6: it.data_len = 10'($urandom_range(17, 64));
      default:    it.data_len = 10'($urandom_range(0, 16));
    endcase
    return it;
  endfunction

  // The card side: picks the next MISO byte from where the transaction stands.
  function automatic req_t card_byte();
    req_t       it;
    logic [7:0] b;
    it.kind       = KIND_BYTE;
    it.cmd_index  = 6'($urandom);
    it.cmd_arg    = $urandom;
    it.resp_type  = 2'($urandom);
    it.read_block = 1'($urandom);
    it.data_len   = 10'($urandom);
    b = 8'($urandom);
    case (sb.phase)
      PH_RESP: begin
        if (resp_mute || $urandom_range(0, 2) == 0) begin
          b[7] = 1'b1;                      // still busy
        end else begin
          case ($urandom_range(0, 4))
            0, 1:    b = 8'h00;
            2, 3:    b = R1_IDLE;
            default: b[7] = 1'b0;           // mostly carries error bits
          endcase
        end
      end
      PH_TOKEN: begin
        if (token_mute || $urandom_range(0, 2) == 0) begin
          if ($urandom_range(0, 1) == 0) b = BYTE_POLL;
          if (b == BYTE_TOKEN) b = BYTE_POLL;
        end else begin
          b = BYTE_TOKEN;
        end
      end
      PH_CRCHI: if ($urandom_range(0, 7) != 0) b = sb.crc16[15:8];
      PH_CRCLO: if ($urandom_range(0, 7) != 0) b = sb.crc16[7:0];
      default: ;
    endcase
    it.rx_byte = b;
    return it;
  endfunction

  // Feed card bytes until the transaction closes; sometimes cut in with a new start.
  task automatic finish_command();
    while (sb.phase != PH_IDLE) begin
      if ($urandom_range(0, 79) == 0) push_item(random_start(), 1'b1);
      else push_item(card_byte(), 1'b1);
      if (!final_stretch && $urandom_range(0, 299) == 0) wait_drained();
    end
  endtask

  task automatic run_command(input req_t start);
    logic [15:0] r_eff;
    logic [15:0] t_eff;
    r_eff = (sb.resp_tries_cfg == 16'd0) ? 16'd1 : sb.resp_tries_cfg;
    t_eff = (sb.tok_tries_cfg == 16'd0) ? 16'd1 : sb.tok_tries_cfg;
    // a silent card only where the tries are few enough to run out quickly
    resp_mute  = (r_eff <= 16'd64) && ($urandom_range(0, 5) == 0);
    token_mute = (t_eff <= 16'd64) && ($urandom_range(0, 5) == 0);
    quiet      = final_stretch || ($urandom_range(0, 3) == 0);
    push_item(start, 1'b1);
    finish_command();
  endtask

  task automatic run_phase(input int budget);
    int target;
    target = useful_items + budget;
    while (useful_items < target) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3)) push_item(card_byte(), 1'b0);
      end
      run_command(random_start());
    end
  endtask

  // Watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    req_t it;
    sb = new();
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= 1'b0;
    out_tready  <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, with the reset register values: bytes to an idle block,
    // all-ones start, then a start that abandons it mid-frame.
    it = '1;
    push_item(it, 1'b0);
    it = '0;
    it.kind = KIND_BYTE;
    push_item(it, 1'b0);
    it = '1;
    it.kind = KIND_START;
    push_item(it, 1'b1);
    push_item(card_byte(), 1'b1);
    it = '0;
    push_item(it, 1'b1);
    finish_command();

    run_phase(250);
    // zero tries act as one; zero dummies close on the last byte
    reconfigure(16'd0, 16'd0, 4'd0);
    run_phase(250);
    reconfigure(16'd1, 16'd1, 4'd15);
    run_phase(250);
    reconfigure(16'hFFFF, 16'hFFFF, 4'd2);
    run_phase(250);
    reconfigure(16'($urandom_range(1, 64)), 16'($urandom_range(1, 64)), 4'($urandom));
    run_phase(250);

    // last stretch runs flat out
    final_stretch = 1'b1;
    quiet         = 1'b1;
    reconfigure(16'd2, 16'd8, 4'($urandom));
    run_phase(200);

    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d items (%0d more to an idle block), checked %0d results, 6 reg settings.",
             useful_items, idle_items, sb.checked);
    $display("Closed %0d: ok %0d, no resp %0d, card err %0d, no token %0d, bad crc %0d",
             sb.done_cnt, sb.status_cnt[ST_OK], sb.status_cnt[ST_RESP_TOUT],
             sb.status_cnt[ST_CARD_ERR], sb.status_cnt[ST_TOK_TOUT],
             sb.status_cnt[ST_CRC_ERR], "; %0d data bytes.", sb.block_bytes);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
